### src/bfx_pkg.sv
`timescale 1ns / 1ps
package bfx_pkg;

  localparam int TAPS     = 128;
  localparam int FADE_LEN = 1024;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_WR_TARGET = 2'd1,
    ACT_COMMIT    = 2'd2,
    ACT_WR_CURR   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] left_in;
    logic [15:0] right_in;
    logic [6:0]  tap_index;
    logic [15:0] tap_left;
    logic [15:0] tap_right;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_BLEND,
    ST_OUT
  } state_t;

endpackage

### src/bfx_queue.sv
`timescale 1ns / 1ps
module bfx_queue
  import bfx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_take,
  output item_t out_item
);

  item_t     mem [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;
  logic      push;
  logic      pop;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;
  assign out_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> count != 2'd0)
    else $error("push lost");

endmodule

### src/bfx_engine.sv
`timescale 1ns / 1ps
module bfx_engine
  import bfx_pkg::*;
#(
  parameter int BLOCK_LEN = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_take,
  input  item_t              item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic               is_sample,
  output logic               crossfading,
  output logic               rejected
);

  localparam int TW = $clog2(TAPS);
  localparam int BW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int FW = $clog2(FADE_LEN + 1);
  localparam int AW = 32 + TW + 1;
  localparam int NW = AW + FW + 2;

  // memories
  logic signed [15:0] hist [TAPS];
  logic signed [15:0] bank_l [2*TAPS];
  logic signed [15:0] bank_r [2*TAPS];

  state_t state, state_next;

  logic          cur_bank;
  logic [FW-1:0] fade_rem;
  logic [BW-1:0] phase;
  logic          pending;
  logic [TW-1:0] hptr;       // slot of newest sample
  logic [TW:0]   k;          // mac counter over 2*TAPS (cur, then target)
  logic [TW:0]   clr;        // clearing pass address
  logic          rd_valid;
  logic          rd_tgt;
  logic          fading;
  logic [FW-1:0] rem_use;

  logic signed [15:0] h_q, tl_q, tr_q;
  logic signed [31:0] pl, pr;
  logic               p_valid, p_tgt;
  logic signed [AW-1:0] acl, acr, atl, atr;

  logic [1:0]          bstep;
  logic signed [NW-1:0] nsum;
  logic signed [15:0]  res_l;

  logic [TW-1:0] widx;
  logic [TW-1:0] hidx;
  logic [TW:0]   k_next;
  logic          rd_en;
  logic          last_rd;
  logic signed [16:0] msum;

  // mac stage: history read address runs from newest backward
  assign hidx    = hptr - k[TW-1:0];
  assign last_rd = fading ? (k == (TW+1)'(2*TAPS - 1)) :
                            (k == (TW+1)'(TAPS - 1));
  assign rd_en   = (state == ST_MAC);
  assign widx    = item.tap_index[TW-1:0];
  assign msum    = 17'($signed(item.left_in)) + 17'($signed(item.right_in));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr == (TW+1)'(2*TAPS - 1)) state_next = ST_IDLE;
      ST_IDLE: if (item_valid) begin
        if (item.action == ACT_SAMPLE) state_next = ST_MAC;
        else state_next = ST_OUT;
      end
      ST_MAC:   if (last_rd) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_valid && !p_valid) state_next = ST_BLEND;
      ST_BLEND: if (bstep == 2'd3) state_next = ST_OUT;
      ST_OUT:   if (out_valid && !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_take = (state == ST_IDLE) && item_valid;
    k_next    = k + (TW+1)'(1);
  end

  // tap and history storage
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      hist[clr[TW-1:0]] <= '0;
      bank_l[clr]       <= '0;
      bank_r[clr]       <= '0;
    end
    if (state == ST_IDLE && item_valid && item.action == ACT_SAMPLE) begin
      hist[hptr + TW'(1)] <= msum[16:1];
    end
    if (state == ST_IDLE && item_valid && 32'(item.tap_index) < TAPS) begin
      if (item.action == ACT_WR_CURR ||
          (item.action == ACT_WR_TARGET && fade_rem == '0)) begin
        bank_l[{cur_bank ^ (item.action == ACT_WR_TARGET), widx}] <= item.tap_left;
        bank_r[{cur_bank ^ (item.action == ACT_WR_TARGET), widx}] <= item.tap_right;
      end
    end
    if (rd_en) begin
      h_q  <= hist[hidx];
      tl_q <= bank_l[{cur_bank ^ k[TW], k[TW-1:0]}];
      tr_q <= bank_r[{cur_bank ^ k[TW], k[TW-1:0]}];
    end
    pl <= h_q * tl_q;
    pr <= h_q * tr_q;
  end

  // blend: n = cur*r + tgt*(F-r), round half up, floor divide by F*2^15
  logic signed [NW-1:0] nround;
  logic signed [NW-1:0] q;
  localparam int SH = 15 + $clog2(FADE_LEN);

  always_comb begin
    nround = nsum + NW'(FADE_LEN) * NW'(16384);
    q      = nround >>> SH;
  end

  logic signed [15:0] sat_q;
  always_comb begin
    if (q > NW'(32767)) sat_q = 16'sh7fff;
    else if (q < -NW'(32768)) sat_q = -16'sh8000;
    else sat_q = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid && item.action != ACT_SAMPLE) begin
      out_left  <= '0;
      out_right <= '0;
    end
    if (state == ST_BLEND) begin
      unique case (bstep)
        2'd0: nsum <= NW'(acl) * $signed({1'b0, rem_use}) +
                      NW'(atl) * $signed({1'b0, FW'(FADE_LEN) - rem_use});
        2'd1: begin
          res_l <= sat_q;
          nsum  <= NW'(acr) * $signed({1'b0, rem_use}) +
                   NW'(atr) * $signed({1'b0, FW'(FADE_LEN) - rem_use});
        end
        2'd2: begin
          out_left  <= res_l;
          out_right <= sat_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      cur_bank <= 1'b0;
      fade_rem <= '0;
      phase    <= '0;
      pending  <= 1'b0;
      hptr     <= '0;
      k        <= '0;
      rd_valid <= 1'b0;
      p_valid  <= 1'b0;
      fading   <= 1'b0;
      bstep    <= '0;
      out_valid <= 1'b0;
      is_sample <= 1'b0;
      crossfading <= 1'b0;
      rejected <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      rd_tgt   <= k[TW];
      p_valid  <= rd_valid;
      p_tgt    <= rd_tgt;
      if (state == ST_CLEAR) clr <= clr + (TW+1)'(1);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_IDLE && item_valid) begin
        k     <= '0;
        bstep <= '0;
        acl <= '0; acr <= '0; atl <= '0; atr <= '0;
        unique case (item.action)
          ACT_SAMPLE: begin
            hptr <= hptr + TW'(1);
            if (phase == '0 && pending && fade_rem == '0) begin
              pending  <= 1'b0;
              fade_rem <= FW'(FADE_LEN);
              fading   <= 1'b1;
              rem_use  <= FW'(FADE_LEN);
            end else begin
              fading  <= (fade_rem != '0);
              rem_use <= (fade_rem != '0) ? fade_rem : FW'(FADE_LEN);
            end
            phase <= (32'(phase) == BLOCK_LEN - 1) ? '0 : phase + BW'(1);
            is_sample <= 1'b1;
            rejected  <= 1'b0;
          end
          ACT_COMMIT: begin
            pending     <= 1'b1;
            is_sample   <= 1'b0;
            rejected    <= 1'b0;
            crossfading <= (fade_rem != '0);
          end
          default: begin
            is_sample   <= 1'b0;
            rejected    <= (item.action == ACT_WR_TARGET) && (fade_rem != '0);
            crossfading <= (fade_rem != '0);
          end
        endcase
      end
      if (state == ST_MAC) k <= k_next;
      if (p_valid) begin
        if (p_tgt) begin
          atl <= atl + AW'(pl);
          atr <= atr + AW'(pr);
        end else begin
          acl <= acl + AW'(pl);
          acr <= acr + AW'(pr);
        end
      end
      if (state == ST_BLEND) begin
        bstep <= bstep + 2'd1;
        if (bstep == 2'd2) begin
          crossfading <= fading;
          if (fading) begin
            fade_rem <= fade_rem - FW'(1);
            if (fade_rem == FW'(1)) cur_bank <= ~cur_bank;
          end
        end
      end
      if (state == ST_OUT && !out_valid) out_valid <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && item_valid) |=> (state == ST_MAC || state == ST_OUT))
    else $error("item not dispatched");
  assert property (@(posedge clk) disable iff (rst) fade_rem <= FW'(FADE_LEN))
    else $error("fade count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (item_take && item.action == ACT_WR_TARGET && fade_rem != '0) |=> rejected)
    else $error("target write during fade not refused");

endmodule

### src/binaural_fir_crossfade_core.sv
`timescale 1ns / 1ps
// Binaural FIR renderer with crossfade. Each sample transfer (action 0) is
// downmixed to mono and filtered by left and right FIRs of TAPS taps; tap
// writes and commits return one status result. A sample reads the taps
// through the single read port of each tap memory into one shared
// multiply-accumulate per ear, and reads both tap banks while a crossfade
// runs. Each item passes through the two-entry queue that decouples input
// and engine, and a stalled result holds the engine until it is taken.
// After reset the block clears its tap and history memories before it
// takes the first item.
module binaural_fir_crossfade_core
  import bfx_pkg::*;
#(
  parameter int BLOCK_LEN = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic [6:0]         tap_index,
  input  logic signed [15:0] tap_left,
  input  logic signed [15:0] tap_right,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic               is_sample,
  output logic               crossfading,
  output logic               rejected
);

  item_t in_item, q_item;
  logic  q_valid, q_take;

  assign in_item = '{action: action_t'(action), left_in: left_in, right_in: right_in,
                     tap_index: tap_index, tap_left: tap_left, tap_right: tap_right};

  bfx_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
  );

  bfx_engine #(.BLOCK_LEN(BLOCK_LEN)) u_engine (
    .clk(clk), .rst(rst), .item_valid(q_valid), .item_take(q_take), .item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_left(out_left),
    .out_right(out_right), .is_sample(is_sample), .crossfading(crossfading),
    .rejected(rejected)
  );

endmodule
